>>> src/fsgs_pkg.sv
// Shared types and constants of the falling sand grid step block.
package fsgs_pkg;

   // Default grid size
   localparam int GridWDef = 64;
   localparam int GridHDef = 36;

   // Action codes of an input word
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_SEED  = 2'd2;
   localparam logic [1:0] ACT_TICK  = 2'd3;

   // Material code register indexes
   localparam logic [2:0] REG_EMPTY = 3'd0;
   localparam logic [2:0] REG_WALL  = 3'd1;
   localparam logic [2:0] REG_SAND  = 3'd2;
   localparam logic [2:0] REG_WATER = 3'd3;
   localparam logic [2:0] REG_SMOKE = 3'd4;
   localparam logic [2:0] REG_FIRE  = 3'd5;
   localparam logic [2:0] REG_LAVA  = 3'd6;
   localparam logic [2:0] REG_PLANT = 3'd7;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] col;
      logic [5:0] row;
      logic [7:0] cell_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  cell_out;
      logic        stepped;
      logic [31:0] frame_count;
   } rsp_type;

endpackage

>>> src/falling_sand_grid_step.sv
// Falling sand grid: cell store, seed sweep, in-place frame scan and spawning.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  req     | req_valid req_ready req_data   | one action word in
//  rsp     | rsp_valid rsp_ready rsp_data   | one result word per action
//  csr     | csr_valid csr_ready csr_index  | material code register writes
//          | csr_data                       |
//
// A write or an off-grid read goes straight to the response state, an in-grid
// read through S_RDWAIT and a tick that does not scan through S_TICK; the next
// word is taken once the result is in the output register. A seed sweeps the
// grid one cell a cycle. A scanning tick visits (GRID_W-2)*(GRID_H-1) cells
// through the single grid memory port pair, then runs the spawn checks; the
// spawn column remainder follows the frame counter.
// Reset is synchronous; the grid itself is not cleared. A new word is taken
// while the previous result still waits in the output register.
module falling_sand_grid_step #(
   parameter int GRID_W = fsgs_pkg::GridWDef,
   parameter int GRID_H = fsgs_pkg::GridHDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fsgs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fsgs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);

   localparam int CELLS = GRID_W * GRID_H;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_W);
   localparam int YW    = $clog2(GRID_H);
   localparam int SpawnDiv = GRID_W - 24;
   localparam int RW    = $clog2(3 * SpawnDiv);
   // added to the remainder when frame*7 wraps past 2^32
   localparam int WrapAdd = SpawnDiv - int'((64'd1 << 32) % SpawnDiv);

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDWAIT = 4'd1;
   localparam logic [3:0] S_SEED   = 4'd2;
   localparam logic [3:0] S_TICK   = 4'd3;
   localparam logic [3:0] S_CELL   = 4'd4;
   localparam logic [3:0] S_M      = 4'd5;
   localparam logic [3:0] S_N1     = 4'd6;
   localparam logic [3:0] S_N2     = 4'd7;
   localparam logic [3:0] S_SW2    = 4'd8;
   localparam logic [3:0] S_SPRD   = 4'd11;
   localparam logic [3:0] S_SPCK   = 4'd12;
   localparam logic [3:0] S_SMRD   = 4'd13;
   localparam logic [3:0] S_SMCK   = 4'd14;
   localparam logic [3:0] S_RESP   = 4'd15;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
      return AW'(AW'(y) * AW'(GRID_W)) + AW'(x);
   endfunction

   // Material code registers
   logic [7:0] code_ff [8];

   // Control and datapath registers
   logic [3:0]    state_ff, state_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [2:0]    mod5_ff, mod5_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] nbr_ff, nbr_in;
   logic [7:0]    m_ff, m_in;
   logic [1:0]    act_ff, act_in;
   logic [31:0]   frame_ff, frame_in;
   logic          seeded_ff, seeded_in;
   logic [7:0]    cell_ff, cell_in;
   logic          stepped_ff, stepped_in;
   logic [31:0]   prod_ff, prod_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   fsgs_pkg::rsp_type rsp_ff, rsp_in;

   // Grid memory
   logic [7:0]    grid_mem [CELLS];
   logic [7:0]    rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= grid_mem[mem_raddr];
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff[fsgs_pkg::REG_EMPTY] <= 8'd0;
         code_ff[fsgs_pkg::REG_WALL]  <= 8'd1;
         code_ff[fsgs_pkg::REG_SAND]  <= 8'd2;
         code_ff[fsgs_pkg::REG_WATER] <= 8'd3;
         code_ff[fsgs_pkg::REG_SMOKE] <= 8'd4;
         code_ff[fsgs_pkg::REG_FIRE]  <= 8'd5;
         code_ff[fsgs_pkg::REG_LAVA]  <= 8'd6;
         code_ff[fsgs_pkg::REG_PLANT] <= 8'd7;
      end else if (csr_valid) begin
         code_ff[csr_index] <= csr_data;
      end
   end

   logic [7:0] c_empty, c_sand, c_water, c_smoke, c_fire;
   assign c_empty = code_ff[fsgs_pkg::REG_EMPTY];
   assign c_sand  = code_ff[fsgs_pkg::REG_SAND];
   assign c_water = code_ff[fsgs_pkg::REG_WATER];
   assign c_smoke = code_ff[fsgs_pkg::REG_SMOKE];
   assign c_fire  = code_ff[fsgs_pkg::REG_FIRE];

   // Seed pattern value of the swept cell; later rules win
   logic [7:0] seed_val;
   logic       lava_x, sand_x;
   always_comb begin
      lava_x = (int'(x_ff) >= 10) && (int'(x_ff) < GRID_W - 10);
      sand_x = 1'b0;
      for (int k = 22; k < 42; k += 3) begin
         if (int'(x_ff) == k) begin
            sand_x = 1'b1;
         end
      end
      seed_val = c_empty;
      if (int'(y_ff) == GRID_H - 1) begin
         seed_val = code_ff[fsgs_pkg::REG_WALL];
      end
      if (lava_x && int'(y_ff) == GRID_H - 6) begin
         seed_val = code_ff[fsgs_pkg::REG_LAVA];
      end
      if (lava_x && mod5_ff == 3'd0 && int'(y_ff) == GRID_H - 7) begin
         seed_val = code_ff[fsgs_pkg::REG_LAVA];
      end
      if (sand_x && int'(y_ff) == 3 + int'(x_ff[0])) begin
         seed_val = c_sand;
      end
      if (int'(x_ff) == 10 && int'(y_ff) == GRID_H - 13) begin
         seed_val = code_ff[fsgs_pkg::REG_PLANT];
      end
      if (int'(x_ff) == GRID_W - 12 && int'(y_ff) == GRID_H - 11) begin
         seed_val = c_fire;
      end
   end

   // Material classes of the cell under update
   logic rd_sand, rd_water, rd_rise;
   logic m_sand, m_water;
   assign rd_sand  = (rdata_ff == c_sand);
   assign rd_water = (rdata_ff == c_water);
   assign rd_rise  = (rdata_ff == c_smoke) || (rdata_ff == c_fire);
   assign m_sand   = (m_ff == c_sand);
   assign m_water  = (m_ff == c_water);

   logic          req_inside, rd_empty, side_right, diag_right;
   logic [XW-1:0] spawn_x;
   assign req_inside = (int'(req_data.col) < GRID_W) && (int'(req_data.row) < GRID_H);
   assign rd_empty   = (rdata_ff == c_empty);
   assign diag_right = frame_ff[0] ^ x_ff[0] ^ y_ff[0];
   assign side_right = frame_ff[0] ^ x_ff[0];
   assign spawn_x    = XW'(12) + XW'(rem_ff);

   // frame*7 and its remainder by GRID_W-24, stepped with the frame counter
   logic [32:0]   prod_step;
   logic [RW-1:0] rem_add, rem_sub1, rem_step;
   assign prod_step = {1'b0, prod_ff} + 33'd7;
   assign rem_add   = rem_ff + RW'(7) + (prod_step[32] ? RW'(WrapAdd) : RW'(0));
   assign rem_sub1  = (int'(rem_add) >= SpawnDiv) ? rem_add - RW'(SpawnDiv) : rem_add;
   assign rem_step  = (int'(rem_sub1) >= SpawnDiv) ? rem_sub1 - RW'(SpawnDiv) : rem_sub1;

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mod5_in      = mod5_ff;
      cur_in       = cur_ff;
      nbr_in       = nbr_ff;
      m_in         = m_ff;
      act_in       = act_ff;
      frame_in     = frame_ff;
      seeded_in    = seeded_ff;
      cell_in      = cell_ff;
      stepped_in   = stepped_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = m_ff;
      mem_raddr    = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_raddr = cell_addr(XW'(req_data.col), YW'(req_data.row));
            if (req_valid) begin
               act_in     = req_data.action;
               cell_in    = 8'd0;
               stepped_in = 1'b0;
               x_in       = '0;
               y_in       = '0;
               mod5_in    = '0;
               unique case (req_data.action)
                  fsgs_pkg::ACT_WRITE: begin
                     mem_we    = req_inside;
                     mem_waddr = mem_raddr;
                     mem_wdata = req_data.cell_in;
                     state_in  = S_RESP;
                  end
                  fsgs_pkg::ACT_READ: begin
                     state_in = req_inside ? S_RDWAIT : S_RESP;
                  end
                  fsgs_pkg::ACT_SEED: begin
                     state_in = S_SEED;
                  end
                  default: begin
                     state_in = seeded_ff ? S_TICK : S_SEED;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            cell_in  = rdata_ff;
            state_in = S_RESP;
         end
         S_SEED: begin
            // one cell a cycle, row by row
            mem_we    = 1'b1;
            mem_waddr = cell_addr(x_ff, y_ff);
            mem_wdata = seed_val;
            mod5_in   = (mod5_ff == 3'd4) ? 3'd0 : mod5_ff + 3'd1;
            x_in      = x_ff + XW'(1);
            if (int'(x_ff) == GRID_W - 1) begin
               x_in    = '0;
               mod5_in = '0;
               y_in    = y_ff + YW'(1);
               if (int'(y_ff) == GRID_H - 1) begin
                  seeded_in = 1'b1;
                  state_in  = (act_ff == fsgs_pkg::ACT_TICK) ? S_TICK : S_RESP;
               end
            end
         end
         S_TICK: begin
            frame_in = frame_ff + 32'd1;
            prod_in  = prod_step[31:0];
            rem_in   = rem_step;
            if (!frame_in[0]) begin
               stepped_in = 1'b1;
               x_in       = XW'(1);
               y_in       = YW'(GRID_H - 2);
               state_in   = S_CELL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CELL: begin
            cur_in    = cell_addr(x_ff, y_ff);
            mem_raddr = cur_in;
            state_in  = S_M;
         end
         S_M: begin
            m_in = rdata_ff;
            if (rd_sand || rd_water) begin
               nbr_in = cur_ff + AW'(GRID_W);
               mem_raddr = nbr_in;
               state_in  = S_N1;
            end else if (rd_rise && int'(y_ff) > 1) begin
               nbr_in = cur_ff - AW'(GRID_W);
               mem_raddr = nbr_in;
               state_in  = S_N1;
            end else begin
               state_in = S_SW2; // no move; S_SW2 rewrites the cell in place
            end
         end
         S_N1: begin
            if (rd_empty) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = rdata_ff;
               state_in  = S_SW2;
            end else if (m_sand) begin
               nbr_in    = diag_right ? cur_ff + AW'(GRID_W + 1)
                                      : cur_ff + AW'(GRID_W - 1);
               mem_raddr = nbr_in;
               state_in  = S_N2;
            end else if (m_water) begin
               nbr_in    = side_right ? cur_ff + AW'(1) : cur_ff - AW'(1);
               mem_raddr = nbr_in;
               state_in  = S_N2;
            end else begin
               state_in = S_SW2;
               nbr_in   = cur_ff;
               m_in     = m_ff;
            end
         end
         S_N2: begin
            if (rd_empty) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = rdata_ff;
            end else begin
               nbr_in = cur_ff;
            end
            state_in = S_SW2;
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      // second half of a swap, then step to the next cell
      if (state_ff == S_SW2) begin
         mem_we    = 1'b1;
         mem_waddr = nbr_ff;
         mem_wdata = m_ff;
         x_in      = x_ff + XW'(1);
         state_in  = S_CELL;
         if (int'(x_ff) == GRID_W - 2) begin
            x_in = XW'(1);
            y_in = y_ff - YW'(1);
            if (y_ff == '0) begin
               state_in = S_SPRD;
            end
         end
      end
      // a cell that does not move rewrites itself
      if (state_ff == S_M && state_in == S_SW2) begin
         nbr_in = cur_ff;
      end

      // sand and smoke spawning into empty cells
      if (state_ff == S_SPRD) begin
         cur_in    = cell_addr(spawn_x, YW'(2));
         mem_raddr = cur_in;
         state_in  = S_SPCK;
      end
      if (state_ff == S_SPCK) begin
         mem_we    = rd_empty;
         mem_waddr = cur_ff;
         mem_wdata = c_sand;
         state_in  = (frame_ff[2:0] == 3'd0) ? S_SMRD : S_RESP;
      end
      if (state_ff == S_SMRD) begin
         cur_in    = cell_addr(XW'(GRID_W - 14), YW'(GRID_H - 13));
         mem_raddr = cur_in;
         state_in  = S_SMCK;
      end
      if (state_ff == S_SMCK) begin
         mem_we    = rd_empty;
         mem_waddr = cur_ff;
         mem_wdata = c_smoke;
         state_in  = S_RESP;
      end

      // result word into the output register once it is free
      if (state_ff == S_RESP && !rsp_valid_in) begin
         rsp_valid_in         = 1'b1;
         rsp_in.cell_out      = cell_ff;
         rsp_in.stepped       = stepped_ff;
         rsp_in.frame_count   = frame_ff;
         state_in             = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_ff     <= '0;
         prod_ff      <= '0;
         rem_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         prod_ff      <= prod_in;
         rem_ff       <= rem_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      mod5_ff    <= mod5_in;
      cur_ff     <= cur_in;
      nbr_ff     <= nbr_in;
      m_ff       <= m_in;
      act_ff     <= act_in;
      cell_ff    <= cell_in;
      stepped_ff <= stepped_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
